// File: rtl/vfqe_pkg.sv
package vfqe_pkg;

  localparam int CHUNK_EDGE = 8;

  localparam int CELL_W = 3;
  localparam int POS_W  = 4;
  localparam int DIR_W  = 3;
  localparam int TEX_W  = 16;
  localparam int ROT_W  = 2;
  localparam int IDX_W  = 32;
  localparam int REC_W  = 3;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [DIR_W-1:0] DIR_Z_NEG = 3'd5;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;

  localparam logic KIND_VERTEX   = 1'b0;
  localparam logic KIND_TRIANGLE = 1'b1;

  localparam logic [REC_W-1:0] REC_FIRST     = 3'd0;
  localparam logic [REC_W-1:0] REC_FIRST_TRI = 3'd4;
  localparam logic [REC_W-1:0] REC_LAST      = 3'd5;

  localparam logic [IDX_W-1:0] VERTS_PER_FACE = 32'd4;

  typedef struct packed {
    logic [CELL_W-1:0] cell_x;
    logic [CELL_W-1:0] cell_y;
    logic [CELL_W-1:0] cell_z;
    logic [DIR_W-1:0]  dir;
    logic [TEX_W-1:0]  tex;
    logic [ROT_W-1:0]  rot;
    logic [IDX_W-1:0]  base;
  } face_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  function automatic logic [CELL_W-1:0] clamp_cell(input logic [CELL_W-1:0] c);
    logic [CELL_W-1:0] r;
    r = c;
    if (int'(c) > CHUNK_EDGE - 1) begin
      r = CELL_W'(CHUNK_EDGE - 1);
    end
    return r;
  endfunction

endpackage

// File: rtl/vfqe_ifs.sv
interface vfqe_face_if
  import vfqe_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [CELL_W-1:0] cell_x;
  logic [CELL_W-1:0] cell_y;
  logic [CELL_W-1:0] cell_z;
  logic [DIR_W-1:0]  face_dir;
  logic [TEX_W-1:0]  texture_id;
  logic [ROT_W-1:0]  rotation;
  logic              start_mesh;

  modport source (
    output valid, cell_x, cell_y, cell_z, face_dir, texture_id, rotation, start_mesh,
    input  ready
  );
  modport sink (
    input  valid, cell_x, cell_y, cell_z, face_dir, texture_id, rotation, start_mesh,
    output ready
  );
endinterface

interface vfqe_rec_if
  import vfqe_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic             kind;
  logic [POS_W-1:0] vert_x;
  logic [POS_W-1:0] vert_y;
  logic [POS_W-1:0] vert_z;
  logic [DIR_W-1:0] normal_dir;
  logic [TEX_W-1:0] vert_texture;
  logic             tex_u;
  logic             tex_v;
  logic [IDX_W-1:0] tri_a;
  logic [IDX_W-1:0] tri_b;
  logic [IDX_W-1:0] tri_c;
  logic             last_of_face;

  modport source (
    output valid, kind, vert_x, vert_y, vert_z, normal_dir, vert_texture, tex_u, tex_v,
           tri_a, tri_b, tri_c, last_of_face,
    input  ready
  );
  modport sink (
    input  valid, kind, vert_x, vert_y, vert_z, normal_dir, vert_texture, tex_u, tex_v,
           tri_a, tri_b, tri_c, last_of_face,
    output ready
  );
endinterface

// File: rtl/voxel_face_quad_expander_unit.sv
// Channel   Direction  Beat
// face_i    in         one block face: cell, direction, texture, rotation, start flag
// rec_o     out        one vertex or triangle record, last_of_face on the sixth
//
// Every face yields six record beats, one per cycle while rec_o is taken; the record
// sequencer loads the next face from the queue as the last record of a face is taken.
// A face passes through the face queue and is then loaded into the sequencer before
// its first record beat.
// Reset clears the vertex count, the face queue and the sequencer.
// The two-entry face queue lets face_i keep taking faces while rec_o stalls, until it is full.
module voxel_face_quad_expander_unit
  import vfqe_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  vfqe_face_if.sink  face_i,
  vfqe_rec_if.source rec_o
);

  face_t         front_face;
  face_t         queue_face;
  logic          push;
  logic          pop;
  queue_status_t q_status;

  vfqe_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .face_i     (face_i),
    .q_status_i (q_status),
    .push_o     (push),
    .face_o     (front_face)
  );

  vfqe_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .face_i   (front_face),
    .pop_i    (pop),
    .face_o   (queue_face),
    .status_o (q_status)
  );

  vfqe_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .face_i     (queue_face),
    .q_status_i (q_status),
    .pop_o      (pop),
    .rec_o      (rec_o)
  );

endmodule

// File: rtl/vfqe_front.sv
module vfqe_front
  import vfqe_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  vfqe_face_if.sink     face_i,
  input  queue_status_t q_status_i,
  output logic          push_o,
  output face_t         face_o
);

  logic [IDX_W-1:0] vcount_q, vcount_d;
  logic [IDX_W-1:0] base;

  assign face_i.ready = !q_status_i.full;
  assign push_o       = face_i.valid && face_i.ready;

  assign base     = face_i.start_mesh ? '0 : vcount_q;
  assign vcount_d = base + VERTS_PER_FACE;

  always_comb begin
    face_o.cell_x = clamp_cell(face_i.cell_x);
    face_o.cell_y = clamp_cell(face_i.cell_y);
    face_o.cell_z = clamp_cell(face_i.cell_z);
    face_o.dir    = (face_i.face_dir > DIR_Z_NEG) ? DIR_Z_NEG : face_i.face_dir;
    face_o.tex    = face_i.texture_id;
    face_o.rot    = face_i.rotation;
    face_o.base   = base;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= '0;
    end else if (push_o) begin
      vcount_q <= vcount_d;
    end
  end

endmodule

// File: rtl/vfqe_queue.sv
module vfqe_queue
  import vfqe_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  face_t         face_i,
  input  logic          pop_i,
  output face_t         face_o,
  output queue_status_t status_o
);

  face_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;
  logic              do_push, do_pop;

  assign status_o.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign status_o.empty = (count_q == '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign face_o         = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= face_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (int'(wr_ptr_q) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (int'(rd_ptr_q) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// File: rtl/vfqe_back.sv
module vfqe_back
  import vfqe_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  face_t         face_i,
  input  queue_status_t q_status_i,
  output logic          pop_o,
  vfqe_rec_if.source    rec_o
);

  face_t            face_q;
  logic             busy_q;
  logic [REC_W-1:0] rec_q;
  logic             rec_done;
  logic             load;
  logic [1:0]       corner;
  logic [1:0]       uv_idx;
  logic             step_a, step_b;
  logic             is_tri;
  logic             second_tri;
  logic [IDX_W-1:0] off_b, off_c;

  assign rec_done = rec_o.valid && rec_o.ready;
  assign pop_o    = !busy_q || (rec_done && rec_q == REC_LAST);
  assign load     = pop_o && !q_status_i.empty;

  always_ff @(posedge clk_i) begin
    if (load) begin
      face_q <= face_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      rec_q  <= REC_FIRST;
    end else if (load) begin
      busy_q <= 1'b1;
      rec_q  <= REC_FIRST;
    end else if (rec_done) begin
      if (rec_q == REC_LAST) begin
        busy_q <= 1'b0;
      end else begin
        rec_q <= rec_q + 1'b1;
      end
    end
  end

  // Corners walk the unit square as (0,0), (1,0), (1,1), (0,1) in the face's plane.
  assign corner     = rec_q[1:0];
  assign step_a     = corner[0] ^ corner[1];
  assign step_b     = corner[1];
  assign uv_idx     = corner + face_q.rot;
  assign is_tri     = (rec_q >= REC_FIRST_TRI);
  assign second_tri = (rec_q == REC_LAST);
  assign off_b      = face_q.dir[0] ? IDX_W'(32'd1 + 32'(second_tri))
                                    : IDX_W'(32'd2 + 32'(second_tri));
  assign off_c      = face_q.dir[0] ? IDX_W'(32'd2 + 32'(second_tri))
                                    : IDX_W'(32'd1 + 32'(second_tri));

  always_comb begin
    rec_o.valid        = busy_q;
    rec_o.normal_dir   = face_q.dir;
    rec_o.last_of_face = second_tri;
    rec_o.kind         = KIND_VERTEX;
    rec_o.vert_x       = '0;
    rec_o.vert_y       = '0;
    rec_o.vert_z       = '0;
    rec_o.vert_texture = '0;
    rec_o.tex_u        = 1'b0;
    rec_o.tex_v        = 1'b0;
    rec_o.tri_a        = '0;
    rec_o.tri_b        = '0;
    rec_o.tri_c        = '0;
    if (is_tri) begin
      rec_o.kind  = KIND_TRIANGLE;
      rec_o.tri_a = face_q.base;
      rec_o.tri_b = face_q.base + off_b;
      rec_o.tri_c = face_q.base + off_c;
    end else begin
      rec_o.vert_x       = POS_W'(face_q.cell_x);
      rec_o.vert_y       = POS_W'(face_q.cell_y);
      rec_o.vert_z       = POS_W'(face_q.cell_z);
      rec_o.vert_texture = face_q.tex;
      rec_o.tex_u        = uv_idx[0] ^ uv_idx[1];
      rec_o.tex_v        = uv_idx[1];
      case (face_q.dir[2:1])
        AXIS_X: begin
          rec_o.vert_y = POS_W'(face_q.cell_y) + POS_W'(step_a);
          rec_o.vert_z = POS_W'(face_q.cell_z) + POS_W'(step_b);
        end
        AXIS_Y: begin
          rec_o.vert_x = POS_W'(face_q.cell_x) + POS_W'(step_a);
          rec_o.vert_z = POS_W'(face_q.cell_z) + POS_W'(step_b);
        end
        default: begin
          rec_o.vert_x = POS_W'(face_q.cell_x) + POS_W'(step_a);
          rec_o.vert_y = POS_W'(face_q.cell_y) + POS_W'(step_b);
        end
      endcase
    end
  end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import vfqe_pkg::*;

  localparam logic [DIR_W-1:0] DIR_X_POS   = 3'd0;
  localparam logic [DIR_W-1:0] DIR_X_NEG   = 3'd1;
  localparam logic [DIR_W-1:0] DIR_Y_POS   = 3'd2;
  localparam logic [DIR_W-1:0] DIR_Y_NEG   = 3'd3;
  localparam logic [DIR_W-1:0] DIR_Z_POS   = 3'd4;
  localparam logic [DIR_W-1:0] DIR_SPARE_A = 3'd6;
  localparam logic [DIR_W-1:0] DIR_SPARE_B = 3'd7;

  localparam int MAX_REPORTS = 40;
  localparam int DRAIN_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 8;

  typedef struct packed {
    logic [CELL_W-1:0] x;
    logic [CELL_W-1:0] y;
    logic [CELL_W-1:0] z;
    logic [DIR_W-1:0]  dir;
    logic [TEX_W-1:0]  tex;
    logic [ROT_W-1:0]  rot;
    logic              start;
  } face_item_t;

  typedef struct packed {
    logic             kind;
    logic [POS_W-1:0] vert_x;
    logic [POS_W-1:0] vert_y;
    logic [POS_W-1:0] vert_z;
    logic [DIR_W-1:0] normal;
    logic [TEX_W-1:0] tex;
    logic             u;
    logic             v;
    logic [IDX_W-1:0] idx_a;
    logic [IDX_W-1:0] idx_b;
    logic [IDX_W-1:0] idx_c;
    logic             last;
  } face_record_t;

  logic clk;
  logic rst_n;

  face_record_t     pending_records[$];
  logic [IDX_W-1:0] mesh_vertex_count;
  int               fault_count;
  int               face_idle_pct;
  int               rec_stall_pct;

  vfqe_face_if face_if ();
  vfqe_rec_if  rec_if ();

  voxel_face_quad_expander_unit u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .face_i (face_if),
    .rec_o  (rec_if)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(negedge clk) begin
    rec_if.ready <= ($urandom_range(0, 99) >= rec_stall_pct);
  end

  function automatic face_item_t make_face(input int x, input int y, input int z,
                                           input logic [DIR_W-1:0] dir, input int tex,
                                           input int rot, input logic start);
    face_item_t f;
    f.x     = CELL_W'(x);
    f.y     = CELL_W'(y);
    f.z     = CELL_W'(z);
    f.dir   = dir;
    f.tex   = TEX_W'(tex);
    f.rot   = ROT_W'(rot);
    f.start = start;
    return f;
  endfunction

  function automatic int limit_cell(input logic [CELL_W-1:0] c);
    int r;
    r = int'(c);
    if (r > CHUNK_EDGE - 1) begin
      r = CHUNK_EDGE - 1;
    end
    return r;
  endfunction

  task automatic predict_face_records(input face_item_t f);
    int               cx;
    int               cy;
    int               cz;
    int               n;
    logic [DIR_W-1:0] d;
    logic [1:0]       grp;
    logic [1:0]       t;
    logic             side;
    logic             up;
    logic [IDX_W-1:0] b;
    face_record_t     r;
    cx = limit_cell(f.x);
    cy = limit_cell(f.y);
    cz = limit_cell(f.z);
    d = (f.dir > DIR_Z_NEG) ? DIR_Z_NEG : f.dir;
    grp = 2'(d >> 1);
    if (f.start) begin
      mesh_vertex_count = '0;
    end
    b = mesh_vertex_count;
    for (n = 0; n < 4; n++) begin
      r = '0;
      r.kind = KIND_VERTEX;
      side = (n == 1) || (n == 2);
      up = (n >= 2);
      case (grp)
        AXIS_X: begin
          r.vert_x = POS_W'(cx);
          r.vert_y = POS_W'(cy + int'(side));
          r.vert_z = POS_W'(cz + int'(up));
        end
        AXIS_Y: begin
          r.vert_x = POS_W'(cx + int'(side));
          r.vert_y = POS_W'(cy);
          r.vert_z = POS_W'(cz + int'(up));
        end
        default: begin
          r.vert_x = POS_W'(cx + int'(side));
          r.vert_y = POS_W'(cy + int'(up));
          r.vert_z = POS_W'(cz);
        end
      endcase
      t = 2'(n) + f.rot;
      r.u = (t == 2'd1) || (t == 2'd2);
      r.v = (t >= 2'd2);
      r.normal = d;
      r.tex = f.tex;
      pending_records.insert(pending_records.size(), r);
    end
    r = '0;
    r.kind = KIND_TRIANGLE;
    r.normal = d;
    r.idx_a = b;
    r.idx_b = d[0] ? b + 32'd1 : b + 32'd2;
    r.idx_c = d[0] ? b + 32'd2 : b + 32'd1;
    pending_records.insert(pending_records.size(), r);
    r.idx_b = d[0] ? b + 32'd2 : b + 32'd3;
    r.idx_c = d[0] ? b + 32'd3 : b + 32'd2;
    r.last = 1'b1;
    pending_records.insert(pending_records.size(), r);
    mesh_vertex_count = b + VERTS_PER_FACE;
  endtask

  task automatic compare_field(input string name, input logic [IDX_W-1:0] want,
                               input logic [IDX_W-1:0] got);
    if (got !== want) begin
      if (fault_count < MAX_REPORTS) begin
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      end
      fault_count++;
    end
  endtask

  always @(posedge clk) begin
    face_record_t want;
    if (rst_n && rec_if.valid && rec_if.ready) begin
      if (pending_records.size() == 0) begin
        if (fault_count < MAX_REPORTS) begin
          $display("%0t: unexpected record beat, expected none, got kind %0b dir %0d",
                   $time, rec_if.kind, rec_if.normal_dir);
        end
        fault_count++;
      end else begin
        want = pending_records.pop_front();
        compare_field("kind", IDX_W'(want.kind), IDX_W'(rec_if.kind));
        compare_field("vert_x", IDX_W'(want.vert_x), IDX_W'(rec_if.vert_x));
        compare_field("vert_y", IDX_W'(want.vert_y), IDX_W'(rec_if.vert_y));
        compare_field("vert_z", IDX_W'(want.vert_z), IDX_W'(rec_if.vert_z));
        compare_field("normal_dir", IDX_W'(want.normal), IDX_W'(rec_if.normal_dir));
        compare_field("vert_texture", IDX_W'(want.tex), IDX_W'(rec_if.vert_texture));
        compare_field("tex_u", IDX_W'(want.u), IDX_W'(rec_if.tex_u));
        compare_field("tex_v", IDX_W'(want.v), IDX_W'(rec_if.tex_v));
        compare_field("tri_a", want.idx_a, rec_if.tri_a);
        compare_field("tri_b", want.idx_b, rec_if.tri_b);
        compare_field("tri_c", want.idx_c, rec_if.tri_c);
        compare_field("last_of_face", IDX_W'(want.last), IDX_W'(rec_if.last_of_face));
      end
    end
  end

  task automatic send_face(input face_item_t f);
    while ($urandom_range(0, 99) < face_idle_pct) begin
      face_if.valid <= 1'b0;
      @(negedge clk);
    end
    face_if.valid      <= 1'b1;
    face_if.cell_x     <= f.x;
    face_if.cell_y     <= f.y;
    face_if.cell_z     <= f.z;
    face_if.face_dir   <= f.dir;
    face_if.texture_id <= f.tex;
    face_if.rotation   <= f.rot;
    face_if.start_mesh <= f.start;
    @(posedge clk);
    while (face_if.ready !== 1'b1) begin
      @(posedge clk);
    end
    predict_face_records(f);
    @(negedge clk);
  endtask

  task automatic wait_for_records();
    int guard;
    guard = 0;
    face_if.valid <= 1'b0;
    while (pending_records.size() != 0 && guard < DRAIN_LIMIT) begin
      @(negedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (pending_records.size() != 0) begin
      $display("%0t: records missing, expected %0d more, got none", $time,
               pending_records.size());
      fault_count++;
      pending_records.delete();
    end
  endtask

  task automatic test_directions();
    logic [DIR_W-1:0] dirs[8];
    int i;
    dirs = '{DIR_X_POS, DIR_X_NEG, DIR_Y_POS, DIR_Y_NEG,
             DIR_Z_POS, DIR_Z_NEG, DIR_SPARE_A, DIR_SPARE_B};
    for (i = 0; i < 8; i++) begin
      send_face(make_face(3, 4, 5, dirs[i], 'h1234 + i, 0, i == 0));
    end
  endtask

  task automatic test_rotations();
    int i;
    for (i = 0; i < 4; i++) begin
      send_face(make_face(2, 6, 1, (i % 2 == 0) ? DIR_Z_POS : DIR_X_NEG, 'h00ff, i, 1'b0));
    end
  endtask

  task automatic test_cell_extremes();
    send_face(make_face(0, 0, 0, DIR_X_POS, 'h0000, 1, 1'b0));
    send_face(make_face(7, 7, 7, DIR_Y_NEG, 'hffff, 2, 1'b0));
    send_face(make_face(7, 0, 7, DIR_Z_NEG, 'haaaa, 3, 1'b0));
    send_face(make_face(0, 7, 0, DIR_Y_POS, 'h5555, 0, 1'b0));
  endtask

  task automatic test_mesh_restart();
    send_face(make_face(1, 2, 3, DIR_X_POS, 'h0101, 0, 1'b0));
    send_face(make_face(4, 5, 6, DIR_Z_NEG, 'h0202, 1, 1'b1));
    send_face(make_face(6, 5, 4, DIR_Y_POS, 'h0303, 2, 1'b1));
    send_face(make_face(3, 2, 1, DIR_X_NEG, 'h0404, 3, 1'b0));
  endtask

  task automatic test_random_faces(input int count);
    face_item_t f;
    int i;
    for (i = 0; i < count; i++) begin
      f.x     = CELL_W'($urandom_range(0, 7));
      f.y     = CELL_W'($urandom_range(0, 7));
      f.z     = CELL_W'($urandom_range(0, 7));
      f.dir   = DIR_W'($urandom_range(0, 7));
      f.tex   = TEX_W'($urandom);
      f.rot   = ROT_W'($urandom_range(0, 3));
      f.start = ($urandom_range(0, 15) == 0);
      send_face(f);
    end
  endtask

  initial begin
    rst_n              = 1'b0;
    face_if.valid      = 1'b0;
    face_if.cell_x     = '0;
    face_if.cell_y     = '0;
    face_if.cell_z     = '0;
    face_if.face_dir   = '0;
    face_if.texture_id = '0;
    face_if.rotation   = '0;
    face_if.start_mesh = 1'b0;
    rec_if.ready       = 1'b0;
    mesh_vertex_count  = '0;
    fault_count        = 0;
    face_idle_pct      = 6;
    rec_stall_pct      = 75;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directions();
    test_rotations();
    test_cell_extremes();
    test_mesh_restart();
    wait_for_records();

    test_random_faces(70);
    wait_for_records();

    face_idle_pct = 75;
    rec_stall_pct = 6;
    test_random_faces(70);
    wait_for_records();

    face_idle_pct = 0;
    rec_stall_pct = 0;
    test_random_faces(70);
    wait_for_records();

    if (fault_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #3ms;
    $display("%0t: timeout with %0d records outstanding", $time, pending_records.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule

// File: files.f
rtl/vfqe_pkg.sv
rtl/vfqe_ifs.sv
rtl/vfqe_front.sv
rtl/vfqe_queue.sv
rtl/vfqe_back.sv
rtl/voxel_face_quad_expander_unit.sv
bench/tb_top.sv
